[sv/krmc_pkg.sv]
// ----------------------------------------------------------------------------
// krmc_pkg - shared types and constants for the key region median change block
// Histogram geometry, opcodes, register indexes, sequencer states and the
// histogram memory control word.
// ----------------------------------------------------------------------------
package krmc_pkg;

    localparam int HIST_BINS      = 256;
    localparam int BIN_AW         = 8;
    localparam int PIX_W          = 8;
    localparam int ROW_W          = 3;
    localparam int COL_W          = 4;
    localparam int OPC_W          = 2;
    localparam int CFG_W          = 8;
    localparam int CFG_IDX_W      = 1;

    localparam int MAX_PIXELS_DEF = 4096;
    localparam int KEY_ROWS_DEF   = 5;
    localparam int KEY_COLS_DEF   = 10;

    localparam logic [CFG_W-1:0] PRESS_THR_RST  = 8'd35;
    localparam logic [CFG_W-1:0] STABLE_TOL_RST = 8'd5;

    localparam logic [OPC_W-1:0] OP_CALIBRATE = 2'd0;
    localparam logic [OPC_W-1:0] OP_DETECT    = 2'd1;
    localparam logic [OPC_W-1:0] OP_VERIFY    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PRESS_THR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_TOL = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INC,
        ST_SCAN,
        ST_REF,
        ST_SUB1,
        ST_SUB2,
        ST_CMP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic              we;
        logic [BIN_AW-1:0] waddr;
        logic [BIN_AW-1:0] raddr;
    } t_hist_ctl;

endpackage

[sv/key_region_median_change_top.sv]
// ----------------------------------------------------------------------------
// key_region_median_change_top - histogram median key press detector
// Each pixel word gets a bin read, then an increment and write of that bin.
// No new pixel word is accepted until the last one is through; the last word
// of a region adds a median scan over the histogram memory before its result
// word is sent.
// Reset: synchronous, active low; a clearing pass over every histogram bin
// follows, during which no word is accepted (config writes are taken).
// ----------------------------------------------------------------------------
module key_region_median_change_top #(
    parameter int MAX_PIXELS = krmc_pkg::MAX_PIXELS_DEF,
    parameter int KEY_ROWS   = krmc_pkg::KEY_ROWS_DEF,
    parameter int KEY_COLS   = krmc_pkg::KEY_COLS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [krmc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [krmc_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,  // pixel, key_row, key_col
    input  logic [krmc_pkg::OPC_W-1:0]      s_axis_tuser,  // opcode
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [15:0]                     m_axis_tdata   // median, changed, overflow
);

    localparam int CW    = $clog2(MAX_PIXELS + 1);
    localparam int AW    = ((CW > krmc_pkg::PIX_W) ? CW : krmc_pkg::PIX_W) + 1;
    localparam int NKEYS = KEY_ROWS * KEY_COLS;
    localparam int SW    = (NKEYS > 1) ? $clog2(NKEYS) : 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PIXELS);

    krmc_pkg::t_state r_state, n_state;
    logic [krmc_pkg::BIN_AW:0]         r_addr, n_addr;
    logic [krmc_pkg::PIX_W-1:0]        r_pix, n_pix;
    logic [krmc_pkg::ROW_W-1:0]        r_row, n_row;
    logic [krmc_pkg::COL_W-1:0]        r_col, n_col;
    logic [krmc_pkg::OPC_W-1:0]        r_op, n_op;
    logic                              r_last, n_last;
    logic [CW-1:0]                     r_count, n_count;
    logic                              r_ovf, n_ovf;
    logic [CW-1:0]                     r_seen, n_seen;
    logic                              r_found, n_found;
    logic [krmc_pkg::PIX_W-1:0]        r_med, n_med;
    logic [krmc_pkg::PIX_W-1:0]        r_diff, n_diff;
    logic                              r_changed, n_changed;
    logic [krmc_pkg::CFG_W-1:0]        r_thr, n_thr;
    logic [krmc_pkg::CFG_W-1:0]        r_tol, n_tol;
    logic                              r_out_valid, n_out_valid;
    logic [krmc_pkg::PIX_W-1:0]        r_out_med, n_out_med;
    logic                              r_out_chg, n_out_chg;
    logic                              r_out_ovf, n_out_ovf;

    logic [krmc_pkg::PIX_W-1:0]        r_ref_mem [NKEYS];
    logic [krmc_pkg::PIX_W-1:0]        r_ref;
    logic                              ref_we;
    logic [SW-1:0]                     slot;
    logic                              key_ok;
    logic                              need_diff;

    krmc_pkg::t_hist_ctl               hist_ctl;
    logic [CW-1:0]                     hist_wdata;
    logic [CW-1:0]                     r_bin;
    logic [krmc_pkg::BIN_AW-1:0]       bin_idx;

    logic                              alu_sub;
    logic [AW-1:0]                     alu_a, alu_b, alu_sum;
    logic                              alu_neg;
    logic                              s_acc;

    assign s_acc     = s_axis_tvalid && s_axis_tready;
    assign key_ok    = (32'(r_row) < KEY_ROWS) && (32'(r_col) < KEY_COLS);
    assign slot      = SW'(32'(r_row) * KEY_COLS + 32'(r_col));
    assign bin_idx   = krmc_pkg::BIN_AW'(r_addr - 1'b1);
    // only detect and verify on a valid key look at the stored reference
    assign need_diff = key_ok && ((r_op == krmc_pkg::OP_DETECT) ||
                                  (r_op == krmc_pkg::OP_VERIFY));

    krmc_hist_mem #(.CW(CW)) u_hist (
        .i_clk   (i_clk),
        .i_ctl   (hist_ctl),
        .i_wdata (hist_wdata),
        .o_rdata (r_bin)
    );

    krmc_alu #(.AW(AW)) u_alu (
        .i_sub (alu_sub),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_sum (alu_sum),
        .o_neg (alu_neg)
    );

    always_ff @(posedge i_clk) begin
        if (ref_we) begin
            r_ref_mem[slot] <= r_med;
        end
        r_ref <= r_ref_mem[slot];
    end

    // shared adder operand select
    always_comb begin
        alu_sub = 1'b0;
        alu_a   = AW'(r_seen);
        alu_b   = AW'(r_bin);
        case (r_state)
            krmc_pkg::ST_INC: begin
                alu_a = AW'(r_bin);
                alu_b = AW'(1'b1);
            end
            krmc_pkg::ST_SUB1: begin
                alu_sub = 1'b1;
                alu_a   = AW'(r_med);
                alu_b   = AW'(r_ref);
            end
            krmc_pkg::ST_SUB2: begin
                alu_sub = 1'b1;
                alu_a   = AW'(r_ref);
                alu_b   = AW'(r_med);
            end
            krmc_pkg::ST_CMP: begin
                alu_sub = 1'b1;
                if (r_op == krmc_pkg::OP_VERIFY) begin
                    alu_a = AW'(r_tol);
                    alu_b = AW'(r_diff);
                end else begin
                    alu_a = AW'(r_diff);
                    alu_b = AW'(r_thr);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_pix       = r_pix;
        n_row       = r_row;
        n_col       = r_col;
        n_op        = r_op;
        n_last      = r_last;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_seen      = r_seen;
        n_found     = r_found;
        n_med       = r_med;
        n_diff      = r_diff;
        n_changed   = r_changed;
        n_thr       = r_thr;
        n_tol       = r_tol;
        n_out_valid = r_out_valid;
        n_out_med   = r_out_med;
        n_out_chg   = r_out_chg;
        n_out_ovf   = r_out_ovf;
        ref_we      = 1'b0;
        s_axis_tready  = 1'b0;
        hist_ctl.we    = 1'b0;
        hist_ctl.waddr = r_pix;
        hist_ctl.raddr = r_addr[krmc_pkg::BIN_AW-1:0];
        hist_wdata     = '0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                krmc_pkg::REG_PRESS_THR:  n_thr = i_cfg_wdata;
                krmc_pkg::REG_STABLE_TOL: n_tol = i_cfg_wdata;
                default: begin
                end
            endcase
        end

        case (r_state)
            krmc_pkg::ST_CLEAR: begin
                hist_ctl.we    = 1'b1;
                hist_ctl.waddr = r_addr[krmc_pkg::BIN_AW-1:0];
                n_addr         = r_addr + 1'b1;
                if (r_addr[krmc_pkg::BIN_AW-1:0] == '1) begin
                    n_addr  = '0;
                    n_state = krmc_pkg::ST_IDLE;
                end
            end
            krmc_pkg::ST_IDLE: begin
                s_axis_tready  = 1'b1;
                hist_ctl.raddr = s_axis_tdata[7:0];
                if (s_acc) begin
                    n_pix   = s_axis_tdata[7:0];
                    n_row   = s_axis_tdata[10:8];
                    n_col   = s_axis_tdata[14:11];
                    n_op    = s_axis_tuser;
                    n_last  = s_axis_tlast;
                    n_state = krmc_pkg::ST_INC;
                end
            end
            krmc_pkg::ST_INC: begin
                if (r_count < MAX_CNT) begin
                    hist_ctl.we = 1'b1;
                    hist_wdata  = alu_sum[CW-1:0];
                    n_count     = r_count + 1'b1;
                end else begin
                    n_ovf = 1'b1;
                end
                if (r_last) begin
                    n_addr  = '0;
                    n_seen  = '0;
                    n_found = 1'b0;
                    n_med   = '0;
                    n_state = krmc_pkg::ST_SCAN;
                end else begin
                    n_state = krmc_pkg::ST_IDLE;
                end
            end
            krmc_pkg::ST_SCAN: begin
                // read data is registered, so r_bin holds the bin one address below r_addr (bin_idx)
                if (r_addr != '0) begin
                    hist_ctl.we    = 1'b1;
                    hist_ctl.waddr = bin_idx;
                    n_seen         = alu_sum[CW-1:0];
                    if (!r_found && (alu_sum > AW'(r_count >> 1))) begin
                        n_found = 1'b1;
                        n_med   = bin_idx;
                    end
                end
                if (r_addr[krmc_pkg::BIN_AW]) begin
                    n_count = '0;
                    n_state = krmc_pkg::ST_REF;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            krmc_pkg::ST_REF: begin
                n_state = krmc_pkg::ST_SUB1;
            end
            krmc_pkg::ST_SUB1: begin
                n_diff  = alu_sum[krmc_pkg::PIX_W-1:0];
                n_state = (need_diff && alu_neg) ? krmc_pkg::ST_SUB2 : krmc_pkg::ST_CMP;
            end
            krmc_pkg::ST_SUB2: begin
                n_diff  = alu_sum[krmc_pkg::PIX_W-1:0];
                n_state = krmc_pkg::ST_CMP;
            end
            krmc_pkg::ST_CMP: begin
                n_changed = key_ok &&
                            (((r_op == krmc_pkg::OP_DETECT) && !alu_neg) ||
                             ((r_op == krmc_pkg::OP_VERIFY) && alu_neg));
                n_state   = krmc_pkg::ST_OUT;
            end
            krmc_pkg::ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_med   = r_med;
                    n_out_chg   = r_changed;
                    n_out_ovf   = r_ovf;
                    n_ovf       = 1'b0;
                    ref_we      = key_ok && (r_op == krmc_pkg::OP_CALIBRATE);
                    n_state     = krmc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = krmc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= krmc_pkg::ST_CLEAR;
            r_addr      <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_thr       <= krmc_pkg::PRESS_THR_RST;
            r_tol       <= krmc_pkg::STABLE_TOL_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_thr       <= n_thr;
            r_tol       <= n_tol;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix     <= n_pix;
        r_row     <= n_row;
        r_col     <= n_col;
        r_op      <= n_op;
        r_last    <= n_last;
        r_seen    <= n_seen;
        r_found   <= n_found;
        r_med     <= n_med;
        r_diff    <= n_diff;
        r_changed <= n_changed;
        r_out_med <= n_out_med;
        r_out_chg <= n_out_chg;
        r_out_ovf <= n_out_ovf;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_ovf, r_out_chg, r_out_med};

endmodule

[sv/krmc_hist_mem.sv]
// ----------------------------------------------------------------------------
// krmc_hist_mem - histogram bin memory
// 256 bins, one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module krmc_hist_mem #(
    parameter int CW = 13
) (
    input  logic                  i_clk,
    input  krmc_pkg::t_hist_ctl   i_ctl,
    input  logic [CW-1:0]         i_wdata,
    output logic [CW-1:0]         o_rdata
);

    logic [CW-1:0] r_mem [krmc_pkg::HIST_BINS];
    logic [CW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_ctl.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/krmc_alu.sv]
// ----------------------------------------------------------------------------
// krmc_alu - shared add/subtract unit
// Bin increment, running sum, absolute difference and threshold compare all
// go through this one adder; the top bit of a subtract is the borrow.
// ----------------------------------------------------------------------------
module krmc_alu #(
    parameter int AW = 14
) (
    input  logic          i_sub,
    input  logic [AW-1:0] i_a,
    input  logic [AW-1:0] i_b,
    output logic [AW-1:0] o_sum,
    output logic          o_neg
);

    logic [AW-1:0] b_op;

    assign b_op  = i_sub ? ~i_b : i_b;
    assign o_sum = i_a + b_op + AW'(i_sub);
    assign o_neg = o_sum[AW-1];

endmodule

[sv/krmc_checker.sv]
// ----------------------------------------------------------------------------
// krmc_checker - port-level checks for the key region median change block
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module krmc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // reset always starts the clearing pass
    a_rst_not_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("ready right after reset");

    // each pixel word needs a bin read before the next one
    a_pixel_two_cycles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("word accepted on consecutive cycles");

    // median scan blocks input after a last word
    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast)
        |=> !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)
        else $error("input taken during median scan");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result word dropped or changed while stalled");

    a_out_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:10] == 6'b0))
        else $error("result padding not zero");

endmodule

bind key_region_median_change_top krmc_checker u_krmc_checker (.*);
